// ===== rtl/fpba_pkg.sv =====
// Package: sizes, codes and beat types of the fit-policy block allocator.
package fpba_pkg;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SIZE_W     = ADDR_BITS + 1;
  localparam int unsigned PID_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;
  localparam logic [1:0] CMD_INIT  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NOPID   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PSIZE  = 1'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pid;
    logic [16:0] req_size;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic [6:0]  free_blocks;
    logic [6:0]  alloc_blocks;
  } out_beat_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] blk_start;
    logic [ADDR_BITS-1:0] blk_end;
  } free_ent_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] blk_start;
    logic [ADDR_BITS-1:0] blk_end;
    logic [PID_W-1:0]     owner;
  } alloc_ent_t;

endpackage

// ===== rtl/fpba_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module fpba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fit_policy_block_allocator_core.sv =====
// Top level: sequenced free-list allocator over a free table and an allocated table.
// Commands run as sequences of table scans and shifts; coalesce is an insertion sort of the
//   free table by start, then a merge pass.
// Flow: one command at a time; the sequencer and the single read port of each
//   table RAM bound the rate. A new beat is taken while a result still waits.
// Reset: asynchronous, active low; both tables empty, policy first fit, partition 65536.
//   Table RAMs are not cleared; only entries below the fill counts are read.
module fit_policy_block_allocator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpba_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpba_pkg::out_beat_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IW = fpba_pkg::IDX_W;
  localparam int unsigned CW = fpba_pkg::CNT_W;
  localparam int unsigned AW = fpba_pkg::ADDR_BITS;
  localparam int unsigned SW = fpba_pkg::SIZE_W;

  typedef enum logic [4:0] {
    S_IDLE, S_ASC_RD, S_ASC_CK, S_FRM_RD, S_FRM_WR,
    S_AI_RD, S_AI_CK, S_AI_SHRD, S_AI_SHWR,
    S_FI_RD, S_FI_CK, S_FI_SHRD, S_FI_SHWR,
    S_DSC_RD, S_DSC_CK, S_AR_RD, S_AR_WR,
    S_CI_RD, S_CI_CK, S_CJ_RD, S_CJ_CK, S_CM_RD, S_CM_CK,
    S_INIT, S_DONE
  } state_e;

  state_e                state_q;
  logic [1:0]            pol_q;
  logic [SW-1:0]         part_q;
  logic [1:0]            cmd_q, status_q;
  logic [15:0]           pid_q;
  logic [SW-1:0]         req_q;
  logic [CW-1:0]         fused_q, aused_q, k_q, j_q, pos_q, w_q;
  logic [AW-1:0]         rs_q, re_q, ins_s_q, ins_e_q;
  logic                  rem_q;
  logic                  out_valid_q;
  fpba_pkg::out_beat_t   out_q;

  fpba_pkg::free_ent_t   fr_rdata, fr_wdata;
  fpba_pkg::alloc_ent_t  al_rdata, al_wdata;
  logic                  fr_we, al_we;
  logic [IW-1:0]         fr_waddr, fr_raddr, al_waddr, al_raddr;

  logic [CW-1:0]         kp1, km1, jm1, wm1;
  logic [SW-1:0]         rd_fsize, ins_sz, psz, ae_full;
  logic                  merge_hit, fi_ordered, ins_before;

  assign kp1 = k_q + CW'(1);
  assign km1 = k_q - CW'(1);
  assign jm1 = j_q - CW'(1);
  assign wm1 = w_q - CW'(1);

  // one shared subtractor on the read port: size of the entry just read
  assign rd_fsize = {1'b0, fr_rdata.blk_end} - {1'b0, fr_rdata.blk_start} + SW'(1);
  assign ins_sz   = {1'b0, ins_e_q} - {1'b0, ins_s_q} + SW'(1);
  assign ae_full  = {1'b0, fr_rdata.blk_start} + req_q - SW'(1);
  assign psz      = (part_q > (SW'(1) << AW)) ? (SW'(1) << AW) : part_q;

  assign fi_ordered = (pol_q == fpba_pkg::POL_BEST) || (pol_q == fpba_pkg::POL_WORST);
  assign ins_before = ((pol_q == fpba_pkg::POL_BEST)  && (rd_fsize > ins_sz)) ||
                      ((pol_q == fpba_pkg::POL_WORST) && (rd_fsize < ins_sz));
  // merge when the block read abuts the last block written
  assign merge_hit  = (w_q != '0) &&
                      (({1'b0, re_q} + SW'(1)) == {1'b0, fr_rdata.blk_start});

  fpba_ram #(.Width($bits(fpba_pkg::free_ent_t)), .Depth(fpba_pkg::MAX_BLOCKS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  fpba_ram #(.Width($bits(fpba_pkg::alloc_ent_t)), .Depth(fpba_pkg::MAX_BLOCKS)) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (al_we),
    .waddr_i (al_waddr),
    .wdata_i (al_wdata),
    .raddr_i (al_raddr),
    .rdata_o (al_rdata)
  );

  // table port control
  always_comb begin
    fr_raddr = k_q[IW-1:0];
    fr_we    = 1'b0;
    fr_waddr = k_q[IW-1:0];
    fr_wdata = fr_rdata;
    al_raddr = k_q[IW-1:0];
    al_we    = 1'b0;
    al_waddr = k_q[IW-1:0];
    al_wdata = al_rdata;
    unique case (state_q)
      S_FRM_RD: fr_raddr = kp1[IW-1:0];
      S_FRM_WR: fr_we = 1'b1;
      S_AI_SHRD: begin
        if (k_q == pos_q) begin
          al_we    = 1'b1;
          al_waddr = pos_q[IW-1:0];
          al_wdata = '{blk_start: rs_q, blk_end: re_q, owner: pid_q};
        end else begin
          al_raddr = km1[IW-1:0];
        end
      end
      S_AI_SHWR: al_we = 1'b1;
      S_FI_SHRD: begin
        if (k_q == pos_q) begin
          fr_we    = 1'b1;
          fr_waddr = pos_q[IW-1:0];
          fr_wdata = '{blk_start: ins_s_q, blk_end: ins_e_q};
        end else begin
          fr_raddr = km1[IW-1:0];
        end
      end
      S_FI_SHWR: fr_we = 1'b1;
      S_AR_RD:   al_raddr = kp1[IW-1:0];
      S_AR_WR:   al_we = 1'b1;
      S_CJ_RD: begin
        if (j_q == '0) begin
          fr_we    = 1'b1;
          fr_waddr = j_q[IW-1:0];
          fr_wdata = '{blk_start: ins_s_q, blk_end: ins_e_q};
        end else begin
          fr_raddr = jm1[IW-1:0];
        end
      end
      S_CJ_CK: begin
        fr_we    = 1'b1;
        fr_waddr = j_q[IW-1:0];
        if (fr_rdata.blk_start <= ins_s_q) begin
          fr_wdata = '{blk_start: ins_s_q, blk_end: ins_e_q};
        end
      end
      S_CM_CK: begin
        fr_we = 1'b1;
        if (merge_hit) begin
          fr_waddr = wm1[IW-1:0];
          fr_wdata = '{blk_start: rs_q, blk_end: fr_rdata.blk_end};
        end else begin
          fr_waddr = w_q[IW-1:0];
        end
      end
      S_INIT: begin
        fr_we    = (psz != '0);
        fr_waddr = '0;
        fr_wdata = '{blk_start: '0, blk_end: AW'(psz - SW'(1))};
      end
      default: ;
    endcase
  end

  // sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pol_q       <= fpba_pkg::POL_FIRST;
      part_q      <= SW'(1) << AW;
      fused_q     <= '0;
      aused_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == fpba_pkg::REG_POLICY) pol_q <= cfg_data_i[1:0];
        if (cfg_index_i == fpba_pkg::REG_PSIZE)  part_q <= cfg_data_i;
      end
      // S_DONE refills the result register itself
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= in_data_i.cmd;
            pid_q    <= in_data_i.pid;
            req_q    <= in_data_i.req_size;
            status_q <= fpba_pkg::ST_OK;
            k_q      <= '0;
            unique case (in_data_i.cmd)
              fpba_pkg::CMD_ALLOC: state_q <= S_ASC_RD;
              fpba_pkg::CMD_FREE:  state_q <= S_DSC_RD;
              fpba_pkg::CMD_MERGE: begin
                k_q     <= CW'(1);
                state_q <= S_CI_RD;
              end
              default:             state_q <= S_INIT;
            endcase
          end
        end
        // allocate: scan free table for first entry large enough
        S_ASC_RD: begin
          if (req_q == '0 || k_q == fused_q) begin
            status_q <= fpba_pkg::ST_NOSPACE;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_ASC_CK;
          end
        end
        S_ASC_CK: begin
          if (rd_fsize >= req_q) begin
            if (aused_q == CW'(fpba_pkg::MAX_BLOCKS)) begin
              status_q <= fpba_pkg::ST_FULL;
              state_q  <= S_DONE;
            end else begin
              rs_q    <= fr_rdata.blk_start;
              re_q    <= ae_full[AW-1:0];
              ins_s_q <= AW'(ae_full + SW'(1));
              ins_e_q <= fr_rdata.blk_end;
              rem_q   <= (rd_fsize != req_q);
              state_q <= S_FRM_RD;
            end
          end else begin
            k_q     <= kp1;
            state_q <= S_ASC_RD;
          end
        end
        S_FRM_RD: begin
          if (kp1 >= fused_q) begin
            fused_q <= fused_q - CW'(1);
            k_q     <= '0;
            state_q <= S_AI_RD;
          end else begin
            state_q <= S_FRM_WR;
          end
        end
        S_FRM_WR: begin
          k_q     <= kp1;
          state_q <= S_FRM_RD;
        end
        // allocated table insert, ascending by start
        S_AI_RD: begin
          if (k_q == aused_q) begin
            pos_q   <= k_q;
            state_q <= S_AI_SHRD;
          end else begin
            state_q <= S_AI_CK;
          end
        end
        S_AI_CK: begin
          if (al_rdata.blk_start > rs_q) begin
            pos_q   <= k_q;
            k_q     <= aused_q;
            state_q <= S_AI_SHRD;
          end else begin
            k_q     <= kp1;
            state_q <= S_AI_RD;
          end
        end
        S_AI_SHRD: begin
          if (k_q == pos_q) begin
            aused_q <= aused_q + CW'(1);
            k_q     <= '0;
            state_q <= rem_q ? S_FI_RD : S_DONE;
          end else begin
            state_q <= S_AI_SHWR;
          end
        end
        S_AI_SHWR: begin
          k_q     <= km1;
          state_q <= S_AI_SHRD;
        end
        // free table insert by policy
        S_FI_RD: begin
          if (!fi_ordered || k_q == fused_q) begin
            pos_q   <= fused_q;
            k_q     <= fused_q;
            state_q <= S_FI_SHRD;
          end else begin
            state_q <= S_FI_CK;
          end
        end
        S_FI_CK: begin
          if (ins_before) begin
            pos_q   <= k_q;
            k_q     <= fused_q;
            state_q <= S_FI_SHRD;
          end else begin
            k_q     <= kp1;
            state_q <= S_FI_RD;
          end
        end
        S_FI_SHRD: begin
          if (k_q == pos_q) begin
            fused_q <= fused_q + CW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_FI_SHWR;
          end
        end
        S_FI_SHWR: begin
          k_q     <= km1;
          state_q <= S_FI_SHRD;
        end
        // deallocate: lowest-address block of the pid
        S_DSC_RD: begin
          if (k_q == aused_q) begin
            status_q <= fpba_pkg::ST_NOPID;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_DSC_CK;
          end
        end
        S_DSC_CK: begin
          if (al_rdata.owner == pid_q) begin
            if (fused_q == CW'(fpba_pkg::MAX_BLOCKS)) begin
              status_q <= fpba_pkg::ST_FULL;
              state_q  <= S_DONE;
            end else begin
              rs_q    <= al_rdata.blk_start;
              re_q    <= al_rdata.blk_end;
              ins_s_q <= al_rdata.blk_start;
              ins_e_q <= al_rdata.blk_end;
              state_q <= S_AR_RD;
            end
          end else begin
            k_q     <= kp1;
            state_q <= S_DSC_RD;
          end
        end
        S_AR_RD: begin
          if (kp1 >= aused_q) begin
            aused_q <= aused_q - CW'(1);
            k_q     <= '0;
            state_q <= S_FI_RD;
          end else begin
            state_q <= S_AR_WR;
          end
        end
        S_AR_WR: begin
          k_q     <= kp1;
          state_q <= S_AR_RD;
        end
        // coalesce: insertion sort by start, then merge pass
        S_CI_RD: begin
          if (k_q >= fused_q) begin
            k_q     <= '0;
            w_q     <= '0;
            state_q <= S_CM_RD;
          end else begin
            state_q <= S_CI_CK;
          end
        end
        S_CI_CK: begin
          ins_s_q <= fr_rdata.blk_start;
          ins_e_q <= fr_rdata.blk_end;
          j_q     <= k_q;
          state_q <= S_CJ_RD;
        end
        S_CJ_RD: begin
          if (j_q == '0) begin
            k_q     <= kp1;
            state_q <= S_CI_RD;
          end else begin
            state_q <= S_CJ_CK;
          end
        end
        S_CJ_CK: begin
          if (fr_rdata.blk_start > ins_s_q) begin
            j_q     <= jm1;
            state_q <= S_CJ_RD;
          end else begin
            k_q     <= kp1;
            state_q <= S_CI_RD;
          end
        end
        S_CM_RD: begin
          if (k_q == fused_q) begin
            fused_q <= w_q;
            state_q <= S_DONE;
          end else begin
            state_q <= S_CM_CK;
          end
        end
        S_CM_CK: begin
          if (merge_hit) begin
            re_q <= fr_rdata.blk_end;
          end else begin
            rs_q <= fr_rdata.blk_start;
            re_q <= fr_rdata.blk_end;
            w_q  <= w_q + CW'(1);
          end
          k_q     <= kp1;
          state_q <= S_CM_RD;
        end
        S_INIT: begin
          fused_q <= (psz != '0) ? CW'(1) : '0;
          aused_q <= '0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // result register free, or being emptied this cycle
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q         <= 1'b1;
            out_q.status        <= status_q;
            out_q.free_blocks   <= fused_q;
            out_q.alloc_blocks  <= aused_q;
            if (status_q == fpba_pkg::ST_OK &&
                (cmd_q == fpba_pkg::CMD_ALLOC || cmd_q == fpba_pkg::CMD_FREE)) begin
              out_q.range_start <= rs_q;
              out_q.range_end   <= re_q;
            end else begin
              out_q.range_start <= '0;
              out_q.range_end   <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/fpba_checker.sv =====
// Port-level checker of the allocator core, bound to the top level.
module fpba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fpba_pkg::out_beat_t out_data_o
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // the input stalls straight after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a beat");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_blocks <= 7'(fpba_pkg::MAX_BLOCKS)) &&
                    (out_data_o.alloc_blocks <= 7'(fpba_pkg::MAX_BLOCKS)))
    else $error("table count beyond capacity");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != fpba_pkg::ST_OK) |->
      (out_data_o.range_start == '0) && (out_data_o.range_end == '0))
    else $error("error beat carries a range");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
